// ===== rtl/gha_pkg.sv =====
package gha_pkg;

    // default sizing
    localparam int DEF_MAX_ENTITIES  = 512;
    localparam int DEF_COMMAND_DEPTH = 32;
    localparam int DEF_VERSION_BITS  = 16;

    // fixed field widths of the words
    localparam int ID_FW  = 9;
    localparam int VER_FW = 16;
    localparam int CNT_FW = 10;

    // entry flag bit positions
    localparam int FLAG_VALID     = 0;
    localparam int FLAG_ACTIVE    = 1;
    localparam int FLAG_DESTROYED = 2;
    localparam int FLAG_W         = 3;

    typedef enum logic [1:0] {
        ACT_CREATE   = 2'd0,
        ACT_DESTROY  = 2'd1,
        ACT_COMMIT   = 2'd2,
        ACT_VALIDATE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TABLE_FULL = 2'd1,
        ST_QUEUE_FULL = 2'd2,
        ST_INVALID    = 2'd3
    } t_status;

    typedef struct packed {
        t_action             action;
        logic [ID_FW-1:0]    entity_id;
        logic [VER_FW-1:0]   entity_version;
    } t_in_word;

    typedef struct packed {
        t_status             status;
        logic [ID_FW-1:0]    handle_id;
        logic [VER_FW-1:0]   handle_version;
        logic                handle_valid;
        logic [CNT_FW-1:0]   active_count;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIFO_RD,
        S_ENT_CHK,
        S_CMT_NEXT,
        S_CMT_CMD,
        S_CMT_ENT,
        S_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic    take;
        logic    fifo_read;
        logic    ent_read_in;
        logic    ent_read_fifo;
        logic    ent_read_cmd;
        logic    cmd_read;
        logic    new_create;
        logic    reuse_create;
        logic    destroy_mark;
        logic    commit_start;
        logic    commit_apply;
        logic    commit_clear;
        logic    set_res;
        t_status res_status;
        logic    res_hvalid;
        logic    res_handle;
        logic    load_out;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        t_action action;
        logic    have_id;
        logic    fifo_nonempty;
        logic    cmd_full;
        logic    id_in_range;
        logic    handle_ok;
        logic    more_cmds;
        logic    out_busy;
    } t_dp_sts;

endpackage

// ===== rtl/generational_handle_allocator.sv =====
// Steps, from accept to result word: create with a new id decodes and then responds; create
//   from the free list reads the free list, then reads and writes the entry; destroy/validate
//   read and check the entry (skipped when the id is out of range); commit runs read queue,
//   read entry, write entry for each of N queued commands.
// Throughput: one word at a time; a stalled result holds the next result and word back.
// Reset: synchronous active-low; clears counters, free list and command queue pointers,
//   and the result valid. Entry, free-list and queue memories are not cleared.
module generational_handle_allocator #(
    parameter int MAX_ENTITIES  = gha_pkg::DEF_MAX_ENTITIES,
    parameter int COMMAND_DEPTH = gha_pkg::DEF_COMMAND_DEPTH,
    parameter int VERSION_BITS  = gha_pkg::DEF_VERSION_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gha_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gha_pkg::t_out_word o_out_word
);
    import gha_pkg::*;

    // Controller sequences each word through the memory read/check/write
    // steps; the datapath owns the entry table, the free list, the command
    // queue and all counters.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    busy;

    gha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_busy     (busy)
    );

    gha_dp #(
        .MAX_ENTITIES  (MAX_ENTITIES),
        .COMMAND_DEPTH (COMMAND_DEPTH),
        .VERSION_BITS  (VERSION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // input word is taken only in idle; result sits in its own register
    assign o_in_stall = busy;

endmodule

// ===== rtl/gha_ctrl.sv =====
module gha_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  gha_pkg::t_dp_sts i_sts,
    output gha_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);
    import gha_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_sts.action)
                    ACT_CREATE: begin
                        if (i_sts.have_id && !i_sts.cmd_full && i_sts.fifo_nonempty)
                            n_state = S_FIFO_RD;
                        else
                            n_state = S_RESP;
                    end
                    ACT_COMMIT: n_state = S_CMT_NEXT;
                    default: begin
                        n_state = i_sts.id_in_range ? S_ENT_CHK : S_RESP;
                    end
                endcase
            end
            S_FIFO_RD:  n_state = S_ENT_CHK;
            S_ENT_CHK:  n_state = S_RESP;
            S_CMT_NEXT: n_state = i_sts.more_cmds ? S_CMT_CMD : S_RESP;
            S_CMT_CMD:  n_state = S_CMT_ENT;
            S_CMT_ENT:  n_state = S_CMT_NEXT;
            S_RESP: begin
                if (!i_sts.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.res_status = ST_OK;
        o_busy = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.take = i_in_valid;
            end
            S_DECODE: begin
                case (i_sts.action)
                    ACT_CREATE: begin
                        if (!i_sts.have_id) begin
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_status = ST_TABLE_FULL;
                        end else if (i_sts.cmd_full) begin
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_status = ST_QUEUE_FULL;
                        end else if (i_sts.fifo_nonempty) begin
                            o_cmd.fifo_read = 1'b1;
                        end else begin
                            o_cmd.new_create = 1'b1;
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_handle = 1'b1;
                        end
                    end
                    ACT_COMMIT: begin
                        o_cmd.commit_start = 1'b1;
                    end
                    default: begin
                        if (i_sts.id_in_range) begin
                            o_cmd.ent_read_in = 1'b1;
                        end else begin
                            o_cmd.set_res    = 1'b1;
                            o_cmd.res_status = ST_INVALID;
                        end
                    end
                endcase
            end
            S_FIFO_RD: begin
                o_cmd.ent_read_fifo = 1'b1;
            end
            S_ENT_CHK: begin
                o_cmd.set_res = 1'b1;
                case (i_sts.action)
                    ACT_CREATE: begin
                        o_cmd.reuse_create = 1'b1;
                        o_cmd.res_handle   = 1'b1;
                    end
                    ACT_DESTROY: begin
                        if (!i_sts.handle_ok) begin
                            o_cmd.res_status = ST_INVALID;
                        end else if (i_sts.cmd_full) begin
                            o_cmd.res_status = ST_QUEUE_FULL;
                            o_cmd.res_hvalid = 1'b1;
                        end else begin
                            o_cmd.destroy_mark = 1'b1;
                            o_cmd.res_hvalid   = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.res_hvalid = i_sts.handle_ok;
                        o_cmd.res_status = i_sts.handle_ok ? ST_OK : ST_INVALID;
                    end
                endcase
            end
            S_CMT_NEXT: begin
                if (i_sts.more_cmds) begin
                    o_cmd.cmd_read = 1'b1;
                end else begin
                    o_cmd.commit_clear = 1'b1;
                    o_cmd.set_res      = 1'b1;
                end
            end
            S_CMT_CMD: begin
                o_cmd.ent_read_cmd = 1'b1;
            end
            S_CMT_ENT: begin
                o_cmd.commit_apply = 1'b1;
            end
            S_RESP: begin
                o_cmd.load_out = !i_sts.out_busy;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/gha_dp.sv =====
module gha_dp #(
    parameter int MAX_ENTITIES  = gha_pkg::DEF_MAX_ENTITIES,
    parameter int COMMAND_DEPTH = gha_pkg::DEF_COMMAND_DEPTH,
    parameter int VERSION_BITS  = gha_pkg::DEF_VERSION_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gha_pkg::t_in_word i_in_word,
    input  gha_pkg::t_dp_cmd  i_cmd,
    output gha_pkg::t_dp_sts  o_sts,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output gha_pkg::t_out_word o_out_word
);
    import gha_pkg::*;

    localparam int ID_W  = $clog2(MAX_ENTITIES);
    localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
    localparam int QA_W  = (COMMAND_DEPTH > 1) ? $clog2(COMMAND_DEPTH) : 1;
    localparam int QC_W  = $clog2(COMMAND_DEPTH + 1);
    localparam int ENT_W = FLAG_W + VERSION_BITS;
    localparam int CMD_W = ID_W + 1;

    // memories
    logic [ENT_W-1:0] mem_ent  [MAX_ENTITIES];
    logic [ID_W-1:0]  mem_fifo [MAX_ENTITIES];
    logic [CMD_W-1:0] mem_cmd  [COMMAND_DEPTH];

    t_in_word          r_in;
    logic [CNT_W-1:0]  r_alloc;
    logic [ID_W-1:0]   r_fifo_head;
    logic [ID_W-1:0]   r_fifo_tail;
    logic [CNT_W-1:0]  r_fifo_count;
    logic [QC_W-1:0]   r_cmd_count;
    logic [QC_W-1:0]   r_idx;
    logic [CNT_W-1:0]  r_active;
    logic [ID_W-1:0]   r_cur_id;
    logic [VERSION_BITS-1:0] r_cur_ver;
    logic              r_cur_rel;
    t_status           r_res_status;
    logic              r_res_hvalid;
    logic              r_res_handle;
    logic              r_out_valid;
    t_out_word         r_out;
    logic [ENT_W-1:0]  r_ent_q;
    logic [ID_W-1:0]   r_fifo_q;
    logic [CMD_W-1:0]  r_cmd_q;

    logic [FLAG_W-1:0]       ent_flags;
    logic [VERSION_BITS-1:0] ent_ver;
    logic [ID_W-1:0]         in_id;
    logic                    ent_rd;
    logic [ID_W-1:0]         ent_rd_addr;
    logic                    ent_we;
    logic [ID_W-1:0]         ent_wr_addr;
    logic [ENT_W-1:0]        ent_wr_data;
    logic                    cmd_push;
    logic [CMD_W-1:0]        cmd_push_data;
    logic                    fifo_push;

    assign ent_flags = r_ent_q[ENT_W-1 -: FLAG_W];
    assign ent_ver   = r_ent_q[VERSION_BITS-1:0];
    assign in_id     = ID_W'(r_in.entity_id);

    assign o_sts.action        = r_in.action;
    assign o_sts.fifo_nonempty = (r_fifo_count != '0);
    assign o_sts.have_id       = (r_fifo_count != '0) || (r_alloc < CNT_W'(MAX_ENTITIES));
    assign o_sts.cmd_full      = (r_cmd_count >= QC_W'(COMMAND_DEPTH));
    assign o_sts.id_in_range   = (32'(r_in.entity_id) < 32'(r_alloc));
    assign o_sts.handle_ok     = (ent_ver == VERSION_BITS'(r_in.entity_version))
                               && ent_flags[FLAG_VALID] && !ent_flags[FLAG_DESTROYED];
    assign o_sts.more_cmds     = (r_idx < r_cmd_count);
    assign o_sts.out_busy      = r_out_valid && i_out_stall;

    // entry read port
    always_comb begin
        ent_rd      = i_cmd.ent_read_in | i_cmd.ent_read_fifo | i_cmd.ent_read_cmd;
        ent_rd_addr = in_id;
        if (i_cmd.ent_read_fifo) ent_rd_addr = r_fifo_q;
        if (i_cmd.ent_read_cmd)  ent_rd_addr = r_cmd_q[ID_W-1:0];
    end

    // entry write port and queue push
    always_comb begin
        ent_we        = 1'b0;
        ent_wr_addr   = r_cur_id;
        ent_wr_data   = r_ent_q;
        cmd_push      = 1'b0;
        cmd_push_data = {1'b0, r_cur_id};
        fifo_push     = 1'b0;
        if (i_cmd.new_create) begin
            ent_we        = 1'b1;
            ent_wr_addr   = r_alloc[ID_W-1:0];
            ent_wr_data   = '0;
            ent_wr_data[VERSION_BITS + FLAG_VALID] = 1'b1;
            cmd_push      = 1'b1;
            cmd_push_data = {1'b0, r_alloc[ID_W-1:0]};
        end else if (i_cmd.reuse_create) begin
            ent_we        = 1'b1;
            ent_wr_data[VERSION_BITS + FLAG_VALID] = 1'b1;
            cmd_push      = 1'b1;
        end else if (i_cmd.destroy_mark) begin
            ent_we        = 1'b1;
            ent_wr_addr   = in_id;
            ent_wr_data[VERSION_BITS + FLAG_DESTROYED] = 1'b1;
            cmd_push      = 1'b1;
            cmd_push_data = {1'b1, in_id};
        end else if (i_cmd.commit_apply) begin
            ent_we = 1'b1;
            if (r_cur_rel) begin
                ent_wr_data = {{FLAG_W{1'b0}}, ent_ver + VERSION_BITS'(1)};
                fifo_push   = (r_fifo_count < CNT_W'(MAX_ENTITIES));
            end else begin
                ent_wr_data[VERSION_BITS + FLAG_ACTIVE] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_rd) r_ent_q <= mem_ent[ent_rd_addr];
        if (ent_we) mem_ent[ent_wr_addr] <= ent_wr_data;
        if (i_cmd.fifo_read) r_fifo_q <= mem_fifo[r_fifo_head];
        if (fifo_push) mem_fifo[r_fifo_tail] <= r_cur_id;
        if (i_cmd.cmd_read) r_cmd_q <= mem_cmd[r_idx[QA_W-1:0]];
        if (cmd_push) mem_cmd[r_cmd_count[QA_W-1:0]] <= cmd_push_data;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) r_in <= i_in_word;
        if (i_cmd.new_create) begin
            r_cur_id  <= r_alloc[ID_W-1:0];
            r_cur_ver <= '0;
        end
        if (i_cmd.ent_read_fifo) r_cur_id <= r_fifo_q;
        if (i_cmd.reuse_create) r_cur_ver <= ent_ver;
        if (i_cmd.ent_read_cmd) begin
            r_cur_id  <= r_cmd_q[ID_W-1:0];
            r_cur_rel <= r_cmd_q[CMD_W-1];
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            r_res_hvalid <= i_cmd.res_hvalid;
            r_res_handle <= i_cmd.res_handle;
        end
        if (i_cmd.load_out) begin
            r_out.status         <= r_res_status;
            r_out.handle_id      <= r_res_handle ? ID_FW'(r_cur_id) : '0;
            r_out.handle_version <= r_res_handle ? VER_FW'(r_cur_ver) : '0;
            r_out.handle_valid   <= r_res_hvalid;
            r_out.active_count   <= CNT_FW'(r_active);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc      <= '0;
            r_fifo_head  <= '0;
            r_fifo_tail  <= '0;
            r_fifo_count <= '0;
            r_cmd_count  <= '0;
            r_idx        <= '0;
            r_active     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.new_create) r_alloc <= r_alloc + CNT_W'(1);
            if (i_cmd.fifo_read) begin
                r_fifo_head <= (r_fifo_head == ID_W'(MAX_ENTITIES - 1)) ? '0
                                                                         : r_fifo_head + ID_W'(1);
            end
            if (fifo_push) begin
                r_fifo_tail <= (r_fifo_tail == ID_W'(MAX_ENTITIES - 1)) ? '0
                                                                         : r_fifo_tail + ID_W'(1);
            end
            case ({fifo_push, i_cmd.fifo_read})
                2'b10:   r_fifo_count <= r_fifo_count + CNT_W'(1);
                2'b01:   r_fifo_count <= r_fifo_count - CNT_W'(1);
                default: r_fifo_count <= r_fifo_count;
            endcase
            if (cmd_push) r_cmd_count <= r_cmd_count + QC_W'(1);
            if (i_cmd.commit_clear) r_cmd_count <= '0;
            if (i_cmd.commit_start) r_idx <= '0;
            if (i_cmd.commit_apply) begin
                r_idx <= r_idx + QC_W'(1);
                if (!r_cur_rel) begin
                    r_active <= r_active + CNT_W'(1);
                end else if (r_active != '0) begin
                    r_active <= r_active - CNT_W'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_cmd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd_count <= QC_W'(COMMAND_DEPTH))
        else $error("command count beyond queue depth");

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_count <= r_alloc)
        else $error("free list holds more ids than allocated");

    a_active_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= r_alloc)
        else $error("active count above allocated count");

    a_commit_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_clear |=> (r_cmd_count == '0))
        else $error("queue not empty after commit");

endmodule
